// File: src/nvcp_pkg.sv
// Shared constants, codes and types of the name/value command parser.
package nvcp_pkg;

    localparam int NUM_NAMES       = 16;
    localparam int MAX_NAME_LEN    = 31;
    localparam int MAX_FRAC_DIGITS = 9;

    localparam int ENTRY_W = 4;
    localparam int POS_W   = 5;
    localparam int LEN_W   = $clog2(MAX_NAME_LEN + 1);
    localparam int CNT_W   = 5;
    localparam int ACC_W   = 31;
    localparam int MANT_W  = 32;
    localparam int FRAC_W  = 4;
    localparam int IDX_W   = 5;
    localparam int MUL_W   = ACC_W + 4;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [MUL_W-1:0]        MANT_MAX   = MUL_W'(32'h7FFF_FFFF);
    localparam logic signed [IDX_W-1:0] IDX_REJECT = 5'sb11111;

    typedef enum logic [2:0] {
        PH_NAME,
        PH_SIGN,
        PH_NUMBER,
        PH_DONE,
        PH_FAIL
    } t_phase;

    typedef struct packed {
        logic               rd_en;
        logic [POS_W-1:0]   rd_addr;
        logic               wr_en;
        logic               wr_last;
        logic [ENTRY_W-1:0] entry;
        logic [POS_W-1:0]   pos;
        logic [7:0]         data;
    } t_dict_req;

    typedef struct packed {
        logic [NUM_NAMES-1:0][7:0]       chars;
        logic [NUM_NAMES-1:0][LEN_W-1:0] lens;
    } t_dict_rd;

endpackage

// File: src/nvcp_ifs.sv
// Handshake channel interfaces for items, results and the configuration write.
interface nvcp_in_if;
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic [nvcp_pkg::ENTRY_W-1:0] entry_index;
    logic [nvcp_pkg::POS_W-1:0]  char_pos;
    logic [7:0]                  data_byte;
    logic                        last_byte;

    modport source (output valid, mode, entry_index, char_pos, data_byte, last_byte,
                    input ready);
    modport sink (input valid, mode, entry_index, char_pos, data_byte, last_byte,
                  output ready);
endinterface

interface nvcp_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [nvcp_pkg::IDX_W-1:0]  name_index;
    logic signed [nvcp_pkg::MANT_W-1:0] value_mantissa;
    logic [nvcp_pkg::FRAC_W-1:0]        frac_digits;

    modport source (output valid, name_index, value_mantissa, frac_digits, input ready);
    modport sink (input valid, name_index, value_mantissa, frac_digits, output ready);
endinterface

interface nvcp_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [nvcp_pkg::CNT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// File: src/name_value_command_parser_core.sv
// Top level of the name/value command parser.
// The block takes one beat per cycle on i_item while i_item.ready is high. A beat with
// mode 0 at a char_pos below 31 writes one dictionary character (entry_index, char_pos);
// with last_byte set it also sets that entry's length. A beat with mode 1 is one byte of
// a frame "name:value#". Each frame beat marked last_byte yields one result on o_result:
// the matched entry and the value as a signed mantissa with a count of fractional digits,
// or index -1 with a zero value when the frame is rejected.
// i_cfg writes the number of dictionary entries that take part in matching;
// the user must write it only while no frame is in progress; the block does not enforce this.
// A frame beat enters the item stage at acceptance, together with the
// registered dictionary row for its position; the result of a last beat is
// loaded from the item stage into the output register once that register is
// free. Throughput is one beat per cycle while i_item.ready is high, set by the
// single read port of the dictionary row memory used once per beat.
// When o_result is stalled, one result waits in the output register and beats
// keep flowing until the next last beat, which waits in the item stage while i_item.ready is low.
// Reset returns the frame state to the start of a name, and the entry lengths
// and entry count to zero; the dictionary characters are not reset and need no clearing pass.
module name_value_command_parser_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nvcp_in_if.sink    i_item,
    nvcp_out_if.source o_result,
    nvcp_cfg_if.sink   i_cfg
);
    import nvcp_pkg::*;

    t_dict_req dict_req;
    t_dict_rd  dict_rd;

    nvcp_dict u_dict (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (dict_req),
        .o_rd    (dict_rd)
    );

    nvcp_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .o_result (o_result),
        .i_cfg    (i_cfg),
        .i_rd     (dict_rd),
        .o_req    (dict_req)
    );

endmodule

// File: src/nvcp_dict.sv
// Dictionary store: character memory by position and the entry length registers.
module nvcp_dict (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  nvcp_pkg::t_dict_req i_req,
    output nvcp_pkg::t_dict_rd  o_rd
);
    import nvcp_pkg::*;

    logic [NUM_NAMES-1:0][7:0]       r_mem [MAX_NAME_LEN];
    logic [NUM_NAMES-1:0][7:0]       r_rd_chars;
    logic [NUM_NAMES-1:0][LEN_W-1:0] r_lens;

    // One row holds one character position of every entry.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.pos][i_req.entry] <= i_req.data;
        end
        if (i_req.rd_en) begin
            r_rd_chars <= r_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lens <= '0;
        end else if (i_req.wr_en && i_req.wr_last) begin
            r_lens[i_req.entry] <= LEN_W'(i_req.pos) + LEN_W'(1);
        end
    end

    assign o_rd.chars = r_rd_chars;
    assign o_rd.lens  = r_lens;

endmodule

// File: src/nvcp_parse.sv
// Frame parser: item stage, frame state, result register and configuration register.
module nvcp_parse (
    input  logic                i_clk,
    input  logic                i_rst_n,
    nvcp_in_if.sink             i_item,
    nvcp_out_if.source          o_result,
    nvcp_cfg_if.sink            i_cfg,
    input  nvcp_pkg::t_dict_rd  i_rd,
    output nvcp_pkg::t_dict_req o_req
);
    import nvcp_pkg::*;

    logic                 r_s1_valid;
    logic [7:0]           r_s1_byte;
    logic                 r_s1_last;
    logic [CNT_W-1:0]     r_name_count;

    t_phase               r_phase, n_phase;
    logic [POS_W-1:0]     r_pos, n_pos;
    logic [NUM_NAMES-1:0] r_mask, n_mask;
    logic                 r_neg, n_neg;
    logic [ACC_W-1:0]     r_acc, n_acc;
    logic [FRAC_W-1:0]    r_frac, n_frac;
    logic                 r_dot, n_dot;
    logic                 r_digit, n_digit;
    logic [ENTRY_W-1:0]   r_matched, n_matched;

    logic                        r_out_valid;
    logic signed [IDX_W-1:0]     r_out_index, n_out_index;
    logic signed [MANT_W-1:0]    r_out_mant, n_out_mant;
    logic [FRAC_W-1:0]           r_out_frac, n_out_frac;

    logic             out_free;
    logic             s1_go;
    logic             accept;
    logic             is_digit;
    logic             num_en;
    logic             hit;
    logic [ENTRY_W-1:0] hit_idx;
    logic [MUL_W-1:0] acc_mul;
    logic [MANT_W-1:0] mag;

    assign out_free       = !r_out_valid || o_result.ready;
    assign s1_go          = r_s1_valid && (!r_s1_last || out_free);
    assign i_item.ready   = !r_s1_valid || s1_go;
    assign accept         = i_item.valid && i_item.ready;
    assign i_cfg.ready    = 1'b1;

    assign o_req.rd_en    = accept && i_item.mode;
    assign o_req.rd_addr  = n_pos;
    assign o_req.wr_en    = accept && !i_item.mode && (i_item.char_pos < POS_W'(MAX_NAME_LEN));
    assign o_req.wr_last  = i_item.last_byte;
    assign o_req.entry    = i_item.entry_index;
    assign o_req.pos      = i_item.char_pos;
    assign o_req.data     = i_item.data_byte;

    assign o_result.valid          = r_out_valid;
    assign o_result.name_index     = r_out_index;
    assign o_result.value_mantissa = r_out_mant;
    assign o_result.frac_digits    = r_out_frac;

    always_comb begin
        is_digit = r_s1_byte inside {[CH_ZERO:CH_NINE]};
        acc_mul  = (MUL_W'(r_acc) << 3) + (MUL_W'(r_acc) << 1) + MUL_W'(r_s1_byte[3:0]);
        hit      = 1'b0;
        hit_idx  = '0;
        // Walk downwards so that the lowest matching entry wins.
        for (int i = NUM_NAMES - 1; i >= 0; i--) begin
            if (r_mask[i] && (i_rd.lens[i] == LEN_W'(r_pos))
                    && (CNT_W'(i) < r_name_count)) begin
                hit     = 1'b1;
                hit_idx = ENTRY_W'(i);
            end
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_mask    = r_mask;
        n_neg     = r_neg;
        n_acc     = r_acc;
        n_frac    = r_frac;
        n_dot     = r_dot;
        n_digit   = r_digit;
        n_matched = r_matched;
        num_en    = 1'b0;
        mag       = '0;
        n_out_index = IDX_REJECT;
        n_out_mant  = '0;
        n_out_frac  = '0;

        if (s1_go) begin
            case (r_phase)
                PH_NAME: begin
                    if (r_s1_byte == CH_COLON) begin
                        if (r_pos == '0 || !hit) begin
                            n_phase = PH_FAIL;
                        end else begin
                            n_matched = hit_idx;
                            n_phase   = PH_SIGN;
                        end
                    end else if (r_s1_byte == CH_NUL
                            || r_pos >= POS_W'(MAX_NAME_LEN - 1)) begin
                        n_phase = PH_FAIL;
                    end else begin
                        for (int i = 0; i < NUM_NAMES; i++) begin
                            n_mask[i] = r_mask[i] && (i_rd.chars[i] == r_s1_byte);
                        end
                        n_pos = r_pos + POS_W'(1);
                    end
                end
                PH_SIGN: begin
                    n_phase = PH_NUMBER;
                    if (r_s1_byte == CH_MINUS) begin
                        n_neg = 1'b1;
                    end else begin
                        num_en = 1'b1;
                    end
                end
                PH_NUMBER: begin
                    num_en = 1'b1;
                end
                default: begin
                end
            endcase

            if (num_en) begin
                if (r_s1_byte == CH_HASH) begin
                    n_phase = r_digit ? PH_DONE : PH_FAIL;
                end else if (r_s1_byte == CH_DOT && !r_dot) begin
                    n_dot = 1'b1;
                end else if (is_digit) begin
                    n_digit = 1'b1;
                    if (!(r_dot && r_frac >= FRAC_W'(MAX_FRAC_DIGITS))) begin
                        if (r_dot) begin
                            n_frac = r_frac + FRAC_W'(1);
                        end
                        n_acc = acc_mul[ACC_W-1:0];
                        if (acc_mul > MANT_MAX) begin
                            n_phase = PH_FAIL;
                        end
                    end
                end else begin
                    n_phase = PH_FAIL;
                end
            end

            if (n_phase == PH_DONE) begin
                mag         = MANT_W'(n_acc);
                n_out_index = IDX_W'({1'b0, n_matched});
                n_out_mant  = n_neg ? (MANT_W'(0) - mag) : mag;
                n_out_frac  = n_frac;
            end

            if (r_s1_last) begin
                n_phase   = PH_NAME;
                n_pos     = '0;
                n_mask    = '1;
                n_neg     = 1'b0;
                n_acc     = '0;
                n_frac    = '0;
                n_dot     = 1'b0;
                n_digit   = 1'b0;
                n_matched = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_name_count <= '0;
            r_phase      <= PH_NAME;
            r_pos        <= '0;
            r_mask       <= '1;
            r_neg        <= 1'b0;
            r_acc        <= '0;
            r_frac       <= '0;
            r_dot        <= 1'b0;
            r_digit      <= 1'b0;
            r_matched    <= '0;
        end else begin
            if (accept && i_item.mode) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go && r_s1_last) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                r_name_count <= i_cfg.data;
            end
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_mask    <= n_mask;
            r_neg     <= n_neg;
            r_acc     <= n_acc;
            r_frac    <= n_frac;
            r_dot     <= n_dot;
            r_digit   <= n_digit;
            r_matched <= n_matched;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_item.mode) begin
            r_s1_byte <= i_item.data_byte;
            r_s1_last <= i_item.last_byte;
        end
        if (s1_go && r_s1_last) begin
            r_out_index <= n_out_index;
            r_out_mant  <= n_out_mant;
            r_out_frac  <= n_out_frac;
        end
    end

    a_frame_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go && r_s1_last |=> r_phase == PH_NAME && r_pos == '0 && r_mask == '1
            && r_acc == '0)
        else $error("Frame state not cleared after the last beat of a frame.");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_index == IDX_REJECT |-> r_out_mant == '0 && r_out_frac == '0)
        else $error("Rejected frame carries a non-zero value.");

    a_frac_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frac <= FRAC_W'(MAX_FRAC_DIGITS))
        else $error("Fraction digit count exceeds its limit.");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(MAX_NAME_LEN - 1))
        else $error("Name position exceeds the name length limit.");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_go |=> r_s1_valid && $stable(r_s1_byte) && $stable(r_s1_last))
        else $error("Stalled frame beat lost or overwritten.");

endmodule

// File: verif/tb_name_value_command_parser_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for the name/value command parser under random idling.
module tb_name_value_command_parser_core;
    import nvcp_pkg::*;

    localparam int QUIET_LIMIT     = 4000;
    localparam int ITEMS_PER_PHASE = 15;

    typedef struct packed {
        logic signed [IDX_W-1:0]  entry;
        logic signed [MANT_W-1:0] mant;
        logic [FRAC_W-1:0]        frac;
    } t_reply;

    class frame_checker;
        logic [7:0]           chars [NUM_NAMES][MAX_NAME_LEN];
        logic [LEN_W-1:0]     lens [NUM_NAMES];
        logic [CNT_W-1:0]     entry_count;
        logic [NUM_NAMES-1:0] alive;
        t_phase               phase;
        int                   name_pos;
        bit                   negative;
        logic [MUL_W-1:0]     magnitude;
        int                   frac_count;
        bit                   dot_seen;
        bit                   digit_seen;
        int                   hit_entry;
        t_reply               awaited [$];
        int                   errors;

        function new();
            foreach (lens[i]) lens[i] = '0;
            entry_count = '0;
            errors = 0;
            restart_frame();
        endfunction

        function void restart_frame();
            alive = '1;
            phase = PH_NAME;
            name_pos = 0;
            negative = 1'b0;
            magnitude = '0;
            frac_count = 0;
            dot_seen = 1'b0;
            digit_seen = 1'b0;
            hit_entry = 0;
        endfunction

        function void set_count(logic [CNT_W-1:0] v);
            entry_count = v;
        endfunction

        function void take_name_char(logic [7:0] b);
            int limit;
            limit = (entry_count < NUM_NAMES) ? int'(entry_count) : NUM_NAMES;
            if (b == CH_COLON) begin
                if (name_pos == 0) begin
                    phase = PH_FAIL;
                    return;
                end
                for (int i = 0; i < limit; i++) begin
                    if (alive[i] && lens[i] == name_pos) begin
                        hit_entry = i;
                        phase = PH_SIGN;
                        return;
                    end
                end
                phase = PH_FAIL;
                return;
            end
            if (b == CH_NUL || name_pos >= MAX_NAME_LEN - 1) begin
                phase = PH_FAIL;
                return;
            end
            for (int i = 0; i < NUM_NAMES; i++) begin
                if (chars[i][name_pos] != b) alive[i] = 1'b0;
            end
            name_pos++;
        endfunction

        function void take_value_char(logic [7:0] b);
            if (b == CH_HASH) begin
                phase = digit_seen ? PH_DONE : PH_FAIL;
                return;
            end
            if (b == CH_DOT && !dot_seen) begin
                dot_seen = 1'b1;
                return;
            end
            if (b >= CH_ZERO && b <= CH_NINE) begin
                digit_seen = 1'b1;
                if (dot_seen) begin
                    if (frac_count >= MAX_FRAC_DIGITS) return;
                    frac_count++;
                end
                magnitude = magnitude * 10 + MUL_W'(b - CH_ZERO);
                if (magnitude > MANT_MAX) phase = PH_FAIL;
                return;
            end
            phase = PH_FAIL;
        endfunction

        function void take_beat(logic mode, logic [ENTRY_W-1:0] entry, logic [POS_W-1:0] pos,
                                logic [7:0] b, logic last);
            t_reply            r;
            logic [MANT_W-1:0] m;
            if (!mode) begin
                if (pos < MAX_NAME_LEN) begin
                    chars[entry][pos] = b;
                    if (last) lens[entry] = LEN_W'(pos + 1);
                end
                return;
            end
            case (phase)
                PH_NAME: take_name_char(b);
                PH_SIGN: begin
                    phase = PH_NUMBER;
                    if (b == CH_MINUS) negative = 1'b1;
                    else take_value_char(b);
                end
                PH_NUMBER: take_value_char(b);
                default: ;
            endcase
            if (!last) return;
            if (phase == PH_DONE) begin
                m = magnitude[MANT_W-1:0];
                if (negative) m = -m;
                r.entry = IDX_W'(hit_entry);
                r.mant  = m;
                r.frac  = FRAC_W'(frac_count);
            end else begin
                r.entry = IDX_REJECT;
                r.mant  = '0;
                r.frac  = '0;
            end
            awaited.push_back(r);
            restart_frame();
        endfunction

        task report(string what);
            $display("MISMATCH @%0t: %s", $time, what);
            errors++;
        endtask

        task check_reply(t_reply got);
            t_reply want;
            if (awaited.size() == 0) begin
                report($sformatf("result %0d/%0d/%0d with none expected",
                                 got.entry, got.mant, got.frac));
                return;
            end
            want = awaited.pop_front();
            if (got.entry !== want.entry)
                report($sformatf("name_index got %0d want %0d", got.entry, want.entry));
            if (got.mant !== want.mant)
                report($sformatf("value_mantissa got %0d want %0d", got.mant, want.mant));
            if (got.frac !== want.frac)
                report($sformatf("frac_digits got %0d want %0d", got.frac, want.frac));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    nvcp_in_if  item_ch();
    nvcp_out_if result_ch();
    nvcp_cfg_if cfg_ch();

    name_value_command_parser_core dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    frame_checker parser_model;
    logic [7:0]   dict_text [NUM_NAMES][MAX_NAME_LEN];
    int           dict_len [NUM_NAMES];
    logic [7:0]   frame_bytes [$];
    int           gap_pct = 0;
    int           stall_pct = 0;
    int           touch_pct = 0;
    int           stall_left = 0;
    int           quiet_cycles = 0;
    int           beats_sent = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (stall_left != 0) begin
            result_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            result_ch.ready <= 1'b0;
            stall_left <= $urandom_range(0, 17);
        end else begin
            result_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n === 1'b1 && result_ch.valid && result_ch.ready)
            parser_model.check_reply(t_reply'({result_ch.name_index, result_ch.value_mantissa,
                                               result_ch.frac_digits}));
    end

    always @(posedge clk) begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [7:0] odd_byte();
        case ($urandom_range(0, 7))
            0: return CH_COLON;
            1: return CH_HASH;
            2: return CH_DOT;
            3: return CH_MINUS;
            4: return CH_NUL;
            5, 6: return CH_ZERO + 8'($urandom_range(0, 9));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task send_beat(logic mode, logic [ENTRY_W-1:0] entry, logic [POS_W-1:0] pos,
                   logic [7:0] b, logic last);
        int gap;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 18);
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.mode        <= mode;
        item_ch.entry_index <= entry;
        item_ch.char_pos    <= pos;
        item_ch.data_byte   <= b;
        item_ch.last_byte   <= last;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        parser_model.take_beat(mode, entry, pos, b, last);
        beats_sent++;
    endtask

    task frame_beat(logic [7:0] b, logic last);
        send_beat(1'b1, ENTRY_W'($urandom_range(0, 15)), POS_W'($urandom_range(0, 31)), b, last);
    endtask

    task dict_beat(int e, int p, logic [7:0] b, logic last);
        send_beat(1'b0, ENTRY_W'(e), POS_W'(p), b, last);
    endtask

    task write_count(logic [CNT_W-1:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        parser_model.set_count(v);
        cfg_ch.valid <= 1'b0;
    endtask

    task settle();
        item_ch.valid <= 1'b0;
        while (parser_model.awaited.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task invent_dictionary();
        int len;
        int r;
        for (int e = 0; e < NUM_NAMES; e++) begin
            if (e > 0 && $urandom_range(0, 7) == 0) begin
                dict_text[e] = dict_text[e-1];
                dict_len[e]  = dict_len[e-1];
                continue;
            end
            r = $urandom_range(0, 19);
            len = (r == 0) ? MAX_NAME_LEN - 1 : (r == 1) ? MAX_NAME_LEN : $urandom_range(1, 8);
            for (int p = 0; p < MAX_NAME_LEN; p++)
                dict_text[e][p] = (p < len) ? 8'($urandom_range(97, 122))
                                            : 8'($urandom_range(0, 255));
            r = $urandom_range(0, 11);
            if (r == 0 && len > 1) dict_text[e][$urandom_range(0, len - 1)] = CH_COLON;
            if (r == 1) dict_text[e][$urandom_range(0, len - 1)] = CH_NUL;
            dict_len[e] = len;
        end
    endtask

    task write_dictionary();
        for (int e = 0; e < NUM_NAMES; e++) begin
            for (int p = 0; p < MAX_NAME_LEN; p++)
                dict_beat(e, p, dict_text[e][p], dict_len[e] != 0 && p == dict_len[e] - 1);
            dict_beat(e, 31, 8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    task name_entry(int e, string s);
        for (int i = 0; i < s.len(); i++) dict_text[e][i] = s[i];
        dict_len[e] = s.len();
    endtask

    task add_text(string s);
        for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
    endtask

    task dictionary_touch();
        int e;
        int p;
        e = $urandom_range(0, NUM_NAMES - 1);
        p = $urandom_range(0, 31);
        if (p == 31) begin
            dict_beat(e, p, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else begin
            if ($urandom_range(0, 3) == 0) dict_text[e][p] = 8'($urandom_range(97, 122));
            dict_beat(e, p, dict_text[e][p], 1'b0);
        end
    endtask

    task send_frame();
        for (int i = 0; i < frame_bytes.size(); i++) begin
            if (touch_pct != 0 && $urandom_range(0, 99) < touch_pct) dictionary_touch();
            frame_beat(frame_bytes[i], i == frame_bytes.size() - 1);
        end
        frame_bytes.delete();
    endtask

    task compose_frame();
        int style;
        int e;
        int n;
        style = $urandom_range(0, 99);
        if (style < 8) begin
            n = $urandom_range(1, 12);
            repeat (n) frame_bytes.push_back(odd_byte());
            return;
        end
        e = $urandom_range(0, NUM_NAMES - 1);
        if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom_range(97, 122)));
        end else begin
            for (int k = 0; k < dict_len[e]; k++) frame_bytes.push_back(dict_text[e][k]);
        end
        frame_bytes.push_back(CH_COLON);
        if ($urandom_range(0, 9) < 3) frame_bytes.push_back(CH_MINUS);
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 11) : $urandom_range(0, 4);
        repeat (n) frame_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 9) < 4) begin
            frame_bytes.push_back(CH_DOT);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 4);
            repeat (n) frame_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        frame_bytes.push_back(CH_HASH);
        if ($urandom_range(0, 6) == 0)
            repeat ($urandom_range(1, 3)) frame_bytes.push_back(odd_byte());
        if (style >= 80) begin
            case ($urandom_range(0, 2))
                0: frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] = odd_byte();
                1: begin
                    n = $urandom_range(1, frame_bytes.size());
                    while (frame_bytes.size() > n) void'(frame_bytes.pop_back());
                end
                default: frame_bytes.insert($urandom_range(0, frame_bytes.size()), odd_byte());
            endcase
        end
    endtask

    task run_phase(logic [CNT_W-1:0] count, int gp, int sp);
        int start;
        settle();
        gap_pct   = gp;
        stall_pct = sp;
        touch_pct = 4;
        write_count(count);
        start = beats_sent;
        while (beats_sent - start < ITEMS_PER_PHASE) begin
            compose_frame();
            send_frame();
        end
    endtask

    initial begin
        parser_model = new();
        rst_n               <= 1'b0;
        item_ch.valid       <= 1'b0;
        item_ch.mode        <= 1'b0;
        item_ch.entry_index <= '0;
        item_ch.char_pos    <= '0;
        item_ch.data_byte   <= '0;
        item_ch.last_byte   <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.data         <= '0;
        gap_pct   = 10;
        stall_pct = 8;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        write_count(CNT_W'(NUM_NAMES));
        invent_dictionary();
        name_entry(0, "a");
        name_entry(1, "speed");
        name_entry(2, "speed");
        name_entry(3, "abcdefghijklmnopqrstuvwxyz0123");
        name_entry(4, "b:c");
        name_entry(5, "abc");
        dict_text[5][1] = CH_NUL;
        dict_len[6] = 0;
        write_dictionary();

        add_text("a:0#");                                 send_frame();
        add_text("speed:-12.5#");                         send_frame();
        add_text("abcdefghijklmnopqrstuvwxyz0123:2147483647#"); send_frame();
        add_text("a:-2147483647#");                       send_frame();
        add_text("a:2147483648#");                        send_frame();
        add_text("a:1.1234567891234#");                   send_frame();
        add_text("speed:-00.0#");                         send_frame();
        add_text(":5#");                                  send_frame();
        add_text("a");
        frame_bytes.push_back(CH_NUL);
        add_text(":1#");                                  send_frame();
        add_text("abcdefghijklmnopqrstuvwxyz01234:1#");   send_frame();
        add_text("zzz:1#");                               send_frame();
        add_text("b:c:1#");                               send_frame();
        add_text("a:1.2.3#");                             send_frame();
        add_text("a:1x#");                                send_frame();
        add_text("a:#");                                  send_frame();
        add_text("a:-#");                                 send_frame();
        add_text("a:12");                                 send_frame();
        add_text("a:12#x9:");                             send_frame();
        add_text("a:1-2#");                               send_frame();
        add_text("a:.5#");                                send_frame();
        add_text("a:5.#");                                send_frame();
        add_text("a");                                    send_frame();
        add_text("a:");                                   send_frame();
        add_text("speed:4");
        foreach (frame_bytes[i]) frame_beat(frame_bytes[i], 1'b0);
        frame_bytes.delete();
        dict_beat(9, 3, dict_text[9][3], 1'b0);
        add_text("2#");                                   send_frame();

        run_phase('0, 20, 8);
        run_phase(CNT_W'(31), 0, 0);
        run_phase(CNT_W'($urandom_range(1, NUM_NAMES - 1)), 15, 15);
        run_phase(CNT_W'(NUM_NAMES), 0, 0);

        item_ch.valid <= 1'b0;
        while (parser_model.awaited.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (parser_model.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: name_value_command_parser_core.f
src/nvcp_pkg.sv
src/nvcp_ifs.sv
src/nvcp_dict.sv
src/nvcp_parse.sv
src/name_value_command_parser_core.sv
verif/tb_name_value_command_parser_core.sv
